@@ sv/fcne_pkg.sv @@
// Shared types, codes and the tone timer reload table of the note envelope unit.
package fcne_pkg;

  // Commands carried by an input item.
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_NOTE = 2'd1;
  localparam logic [1:0] CMD_REST = 2'd2;

  // Kinds of result item.
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_NOTE = 2'd1;
  localparam logic [1:0] KIND_REST = 2'd2;

  // Envelope phases; the unused code zero behaves as decay.
  localparam logic [1:0] PH_ATTACK = 2'd1;
  localparam logic [1:0] PH_HOLD   = 2'd2;
  localparam logic [1:0] PH_DECAY  = 2'd3;

  localparam int          WORD_BITS  = 31;
  localparam logic [30:0] WORD_RESET = 31'd543162304;
  localparam int          TABLE_LEN  = 48;
  localparam int          SEMITONES  = 12;

  typedef logic [WORD_BITS-1:0] env_word_t;

  // Envelope state of one channel, apart from the duration counter.
  typedef struct packed {
    logic [1:0] phase;
    logic [6:0] level;
    logic [6:0] hold_left;
  } chan_state_t;

  // Pitch of a started note.
  typedef struct packed {
    logic [7:0] reload;
    logic [2:0] octave;
  } pitch_res_t;

  localparam logic [7:0] RELOAD_TABLE [TABLE_LEN] = '{
    8'd239, 8'd225, 8'd213, 8'd201, 8'd190, 8'd179, 8'd169, 8'd159,
    8'd151, 8'd142, 8'd134, 8'd127, 8'd119, 8'd113, 8'd106, 8'd100,
    8'd95,  8'd89,  8'd84,  8'd80,  8'd75,  8'd71,  8'd67,  8'd63,
    8'd60,  8'd56,  8'd53,  8'd50,  8'd47,  8'd45,  8'd42,  8'd40,
    8'd38,  8'd36,  8'd34,  8'd32,  8'd30,  8'd28,  8'd27,  8'd25,
    8'd24,  8'd22,  8'd21,  8'd20,  8'd19,  8'd18,  8'd17,  8'd16
  };

endpackage

@@ sv/fcne_tick_unit.sv @@
// Envelope step of one channel for one tick, shared by all channels in turn.
module fcne_tick_unit
  import fcne_pkg::*;
#(
  parameter int DURATION_BITS = 16
) (
  input  env_word_t                word,
  input  chan_state_t              cur,
  input  logic [DURATION_BITS-1:0] remaining,
  output chan_state_t              nxt,
  output logic [DURATION_BITS-1:0] remaining_next,
  output logic                     written
);

  logic [6:0]               want;
  logic [6:0]               attack;
  logic [6:0]               hold;
  logic [6:0]               decay;
  logic [7:0]               sum;
  logic [DURATION_BITS-1:0] hold_wide;

  assign want      = word[6:0];
  assign attack    = word[13:7];
  assign hold      = word[20:14];
  assign decay     = word[27:21];
  assign sum       = {1'b0, cur.level} + {1'b0, attack};
  assign hold_wide = {{(DURATION_BITS-7){1'b0}}, hold};

  always_comb begin
    remaining_next = (remaining != '0) ? remaining - 1'b1 : remaining;
    nxt            = cur;
    written        = 1'b0;
    priority if (cur.phase == PH_ATTACK) begin
      written = 1'b1;
      if (sum >= {1'b0, want}) begin
        nxt.phase     = PH_HOLD;
        nxt.level     = want;
        nxt.hold_left = (remaining_next < hold_wide) ? remaining_next[6:0] : hold;
      end else begin
        nxt.level = sum[6:0];
      end
    end else if (cur.phase == PH_HOLD) begin
      if (cur.hold_left == '0) begin
        nxt.phase = PH_DECAY;
      end else begin
        nxt.hold_left = cur.hold_left - 1'b1;
      end
    end else if (cur.level != '0) begin
      // A zero decay step still takes one off per tick.
      written = 1'b1;
      if (cur.level > decay) begin
        nxt.level = cur.level - decay - ((decay == '0) ? 7'd1 : 7'd0);
      end else begin
        nxt.level = '0;
      end
    end
  end

endmodule

@@ sv/fcne_pitch_unit.sv @@
// Octave search for a new note, one semitone octave per cycle, then the table lookup.
module fcne_pitch_unit
  import fcne_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  base_octave,
  input  logic [7:0]  height,
  output logic        done,
  output pitch_res_t  res
);

  logic              busy;
  logic [2:0]        octave;
  logic signed [9:0] h;
  logic signed [9:0] idx;
  logic [5:0]        idx_clamped;

  assign idx = h + 10'sd12;

  always_comb begin
    priority if (idx < 10'sd0) begin
      idx_clamped = '0;
    end else if (idx > 10'(TABLE_LEN - 1)) begin
      idx_clamped = 6'(TABLE_LEN - 1);
    end else begin
      idx_clamped = idx[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      done   <= 1'b0;
      octave <= base_octave;
      h      <= {{2{height[7]}}, height};
    end else if (busy) begin
      if (!h[9] && octave != '0) begin
        octave <= octave - 1'b1;
        h      <= h - 10'(SEMITONES);
      end else begin
        busy       <= 1'b0;
        done       <= 1'b1;
        res.octave <= octave;
        res.reload <= RELOAD_TABLE[idx_clamped];
      end
    end
  end

endmodule

@@ sv/four_channel_note_envelope.sv @@
// Four-channel note envelope and pitch unit: sequencer, channel state and output register.
// A tick item steps the channels in turn, each channel going through
// the single shared envelope step unit, and gives one result item per channel.
// A note item runs the iterative octave search and then the table lookup; a note item
// and a rest item each give one result item. The input is ready only when idle.
// Synchronous active-high reset: all channels in decay, level, duration and hold zero,
// and every envelope word at its default; no result item is pending after reset.
module four_channel_note_envelope
  import fcne_pkg::*;
#(
  parameter int CHANNELS      = 4,
  parameter int DURATION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  // Input items.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [1:0]  channel,
  input  logic [7:0]  pitch_height,
  input  logic [15:0] note_length,
  // Result items.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_kind,
  output logic [1:0]  out_channel,
  output logic [6:0]  volume_level,
  output logic        volume_written,
  output logic [7:0]  timer_reload,
  output logic [2:0]  octave_select,
  output logic        last_result
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_NOTE_START,
    S_NOTE_WAIT,
    S_REST
  } state_t;

  state_t state;

  // Per-channel state; each array is only ever read at the one selected channel.
  env_word_t                env_word  [CHANNELS];
  logic [1:0]               phase     [CHANNELS];
  logic [6:0]               level     [CHANNELS];
  logic [DURATION_BITS-1:0] remaining [CHANNELS];
  logic [6:0]               hold_left [CHANNELS];

  // Latched item.
  logic [1:0]               ch_r;
  logic [7:0]               height_r;
  logic [DURATION_BITS-1:0] len_r;
  logic [CW-1:0]            cnt;

  logic [CW+1:0]            ch_wide;
  logic [CW+1:0]            cnt_wide;
  logic [CW+1:0]            cfg_wide;
  logic [CW-1:0]            sel;
  logic [DURATION_BITS+15:0] len_wide;
  logic                     channel_ok;
  logic                     cfg_ok;
  logic                     out_free;

  chan_state_t              cur;
  chan_state_t              nxt;
  logic [DURATION_BITS-1:0] remaining_next;
  logic                     tick_written;

  logic                     pitch_start;
  logic                     pitch_done;
  pitch_res_t               pitch_res;

  assign ch_wide    = {{CW{1'b0}}, ch_r};
  assign cnt_wide   = {2'b00, cnt};
  assign cfg_wide   = {{CW{1'b0}}, cfg_index};
  assign len_wide   = {{DURATION_BITS{1'b0}}, note_length};
  assign channel_ok = ({{CW{1'b0}}, channel} < (CW+2)'(CHANNELS));
  assign cfg_ok     = (cfg_wide < (CW+2)'(CHANNELS));

  // One channel is in focus at a time: the tick counter or the addressed channel.
  assign sel = (state == S_TICK) ? cnt : ch_wide[CW-1:0];

  assign cur.phase     = phase[sel];
  assign cur.level     = level[sel];
  assign cur.hold_left = hold_left[sel];

  assign cfg_ready   = (state == S_IDLE);
  assign in_ready    = (state == S_IDLE);
  assign out_free    = !out_valid || out_ready;
  assign pitch_start = (state == S_NOTE_START);

  fcne_tick_unit #(
    .DURATION_BITS(DURATION_BITS)
  ) u_tick (
    .word          (env_word[sel]),
    .cur           (cur),
    .remaining     (remaining[sel]),
    .nxt           (nxt),
    .remaining_next(remaining_next),
    .written       (tick_written)
  );

  fcne_pitch_unit u_pitch (
    .clk        (clk),
    .rst        (rst),
    .start      (pitch_start),
    .base_octave(env_word[sel][30:28]),
    .height     (height_r),
    .done       (pitch_done),
    .res        (pitch_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        env_word[i]  <= WORD_RESET;
        phase[i]     <= PH_DECAY;
        level[i]     <= '0;
        remaining[i] <= '0;
        hold_left[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // Configuration is written only while the block is idle.
      if (cfg_valid && cfg_ready && cfg_ok) begin
        env_word[cfg_wide[CW-1:0]] <= cfg_data;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ch_r     <= channel;
            height_r <= pitch_height;
            len_r    <= len_wide[DURATION_BITS-1:0];
            cnt      <= '0;
            // Command three, and a note or rest for a channel that does not exist, give no result.
            priority if (command == CMD_TICK) begin
              state <= S_TICK;
            end else if (command == CMD_NOTE && channel_ok) begin
              state <= S_NOTE_START;
            end else if (command == CMD_REST && channel_ok) begin
              state <= S_REST;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        S_TICK: begin
          if (out_free) begin
            phase[sel]     <= nxt.phase;
            level[sel]     <= nxt.level;
            hold_left[sel] <= nxt.hold_left;
            remaining[sel] <= remaining_next;
            out_valid      <= 1'b1;
            result_kind    <= KIND_TICK;
            out_channel    <= cnt_wide[1:0];
            volume_level   <= nxt.level;
            volume_written <= tick_written;
            timer_reload   <= '0;
            octave_select  <= '0;
            last_result    <= (cnt == LAST_CH);
            if (cnt == LAST_CH) begin
              state <= S_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end

        S_NOTE_START: begin
          state <= S_NOTE_WAIT;
        end

        S_NOTE_WAIT: begin
          if (pitch_done && out_free) begin
            phase[sel]     <= PH_ATTACK;
            remaining[sel] <= len_r;
            out_valid      <= 1'b1;
            result_kind    <= KIND_NOTE;
            out_channel    <= ch_r;
            volume_level   <= cur.level;
            volume_written <= 1'b0;
            timer_reload   <= pitch_res.reload;
            octave_select  <= pitch_res.octave;
            last_result    <= 1'b1;
            state          <= S_IDLE;
          end
        end

        S_REST: begin
          if (out_free) begin
            // The stored level stays; only the reported volume is silent.
            phase[sel]     <= PH_DECAY;
            remaining[sel] <= len_r;
            out_valid      <= 1'b1;
            result_kind    <= KIND_REST;
            out_channel    <= ch_r;
            volume_level   <= '0;
            volume_written <= 1'b1;
            timer_reload   <= '0;
            octave_select  <= '0;
            last_result    <= 1'b1;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/note_envelope_checker.sv @@
// Channel watcher for the note envelope unit: predicts each result item and compares it.
module note_envelope_checker
  import fcne_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [1:0]  channel,
  input  logic [7:0]  pitch_height,
  input  logic [15:0] note_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  result_kind,
  input  logic [1:0]  out_channel,
  input  logic [6:0]  volume_level,
  input  logic        volume_written,
  input  logic [7:0]  timer_reload,
  input  logic [2:0]  octave_select,
  input  logic        last_result,
  output int          mismatches,
  output int          results_due
);

  localparam int NCH = 4;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] chan;
    logic [6:0] volume;
    logic       written;
    logic [7:0] reload;
    logic [2:0] octave;
    logic       last;
  } result_t;

  // Tone timer reload per semitone, kept apart from the design's own copy.
  localparam logic [7:0] PITCH_RELOAD [48] = '{
    8'd239, 8'd225, 8'd213, 8'd201, 8'd190, 8'd179, 8'd169, 8'd159,
    8'd151, 8'd142, 8'd134, 8'd127, 8'd119, 8'd113, 8'd106, 8'd100,
    8'd95,  8'd89,  8'd84,  8'd80,  8'd75,  8'd71,  8'd67,  8'd63,
    8'd60,  8'd56,  8'd53,  8'd50,  8'd47,  8'd45,  8'd42,  8'd40,
    8'd38,  8'd36,  8'd34,  8'd32,  8'd30,  8'd28,  8'd27,  8'd25,
    8'd24,  8'd22,  8'd21,  8'd20,  8'd19,  8'd18,  8'd17,  8'd16
  };

  env_word_t   words      [NCH];
  logic [1:0]  phases     [NCH];
  logic [6:0]  levels     [NCH];
  logic [15:0] ticks_left [NCH];
  logic [6:0]  holds      [NCH];
  result_t     due_q [$];

  initial mismatches = 0;
  initial results_due = 0;

  // One envelope step of one channel during a tick.
  task automatic step_channel(input int c, output result_t r);
    logic [6:0] want, atk, hld, dec, lv;
    logic [7:0] sum;
    logic       wr;
    want = words[c][6:0];
    atk  = words[c][13:7];
    hld  = words[c][20:14];
    dec  = words[c][27:21];
    lv   = levels[c];
    wr   = 1'b0;
    if (ticks_left[c] != 16'd0) ticks_left[c] = ticks_left[c] - 16'd1;
    if (phases[c] == PH_ATTACK) begin
      sum = {1'b0, lv} + {1'b0, atk};
      if (sum >= {1'b0, want}) begin
        phases[c] = PH_HOLD;
        lv = want;
        holds[c] = (ticks_left[c] < 16'(hld)) ? ticks_left[c][6:0] : hld;
      end else begin
        lv = sum[6:0];
      end
      wr = 1'b1;
    end else if (phases[c] == PH_HOLD) begin
      if (holds[c] == 7'd0) phases[c] = PH_DECAY;
      else holds[c] = holds[c] - 7'd1;
    end else if (lv != 7'd0) begin
      // Any other phase decays; a zero step still takes one off.
      if (lv > dec) begin
        lv = lv - dec;
        if (dec == 7'd0) lv = lv - 7'd1;
      end else begin
        lv = 7'd0;
      end
      wr = 1'b1;
    end
    levels[c] = lv;
    r = '{KIND_TICK, 2'(c), lv, wr, 8'd0, 3'd0, (c == NCH - 1)};
  endtask

  task automatic start_note(input logic [1:0] ch, input logic signed [7:0] height,
                            input logic [15:0] len, output result_t r);
    int         h, idx;
    logic [2:0] oct;
    oct = words[ch][30:28];
    h = height;
    while (h >= 0 && oct > 3'd0) begin
      oct = oct - 3'd1;
      h = h - SEMITONES;
    end
    idx = h + SEMITONES;
    if (idx < 0) idx = 0;
    if (idx > TABLE_LEN - 1) idx = TABLE_LEN - 1;
    phases[ch] = PH_ATTACK;
    ticks_left[ch] = len;
    r = '{KIND_NOTE, ch, levels[ch], 1'b0, PITCH_RELOAD[idx], oct, 1'b1};
  endtask

  function automatic int field_differs(string name, logic [7:0] expected,
                                       logic [7:0] actual);
    if (actual === expected) return 0;
    $error("%s: expected %0d, actual %0d", name, expected, actual);
    return 1;
  endfunction

  always @(posedge clk) begin : watch
    result_t got, exp_r, r;
    int      bad;
    bad = 0;
    if (rst) begin
      for (int c = 0; c < NCH; c++) begin
        words[c] = WORD_RESET;
        phases[c] = PH_DECAY;
        levels[c] = 7'd0;
        ticks_left[c] = 16'd0;
        holds[c] = 7'd0;
      end
      due_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{result_kind, out_channel, volume_level, volume_written,
                timer_reload, octave_select, last_result};
        if (due_q.size() == 0) begin
          $error("result item with nothing expected: kind %0d channel %0d",
                 got.kind, got.chan);
          bad = 1;
        end else begin
          exp_r = due_q.pop_front();
          bad += field_differs("result_kind", exp_r.kind, got.kind);
          bad += field_differs("out_channel", exp_r.chan, got.chan);
          bad += field_differs("volume_level", exp_r.volume, got.volume);
          bad += field_differs("volume_written", exp_r.written, got.written);
          bad += field_differs("timer_reload", exp_r.reload, got.reload);
          bad += field_differs("octave_select", exp_r.octave, got.octave);
          bad += field_differs("last_result", exp_r.last, got.last);
        end
      end
      if (cfg_valid && cfg_ready) words[cfg_index] = cfg_data;
      if (in_valid && in_ready) begin
        case (command)
          CMD_TICK: begin
            for (int c = 0; c < NCH; c++) begin
              step_channel(c, r);
              due_q.push_back(r);
            end
          end
          CMD_NOTE: begin
            start_note(channel, pitch_height, note_length, r);
            due_q.push_back(r);
          end
          CMD_REST: begin
            phases[channel] = PH_DECAY;
            ticks_left[channel] = note_length;
            due_q.push_back('{KIND_REST, channel, 7'd0, 1'b1, 8'd0, 3'd0, 1'b1});
          end
          default: ;
        endcase
      end
    end
    mismatches <= mismatches + bad;
    results_due <= due_q.size();
  end

endmodule

@@ tb/four_channel_note_envelope_tb.sv @@
// Stimulus and verdict for the four-channel note envelope unit, with its checker alongside.
module four_channel_note_envelope_tb;
  import fcne_pkg::*;

  // Generous bound on the run.
  localparam int LIMIT = 500000;
  // Quiet cycles after the last result, as a margin before the words are rewritten; the
  // unit is already idle once its last result has been taken.
  localparam int SETTLE = 16;
  localparam int RANDOM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 58;
  // The fourth command code is not defined; the unit is expected to ignore it.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  // Envelope word of channel i sits at register index REG_ENV_CH0 + i.
  localparam logic [1:0] REG_ENV_CH0 = 2'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = '0;
  logic [1:0]  channel = '0;
  logic [7:0]  pitch_height = '0;
  logic [15:0] note_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [1:0]  out_channel;
  logic [6:0]  volume_level;
  logic        volume_written;
  logic [7:0]  timer_reload;
  logic [2:0]  octave_select;
  logic        last_result;

  int        mismatches;
  int        results_due;
  int        cycles = 0;
  // While calm is set neither side inserts any gap, so the unit runs flat out.
  bit        calm = 1'b0;
  env_word_t plan [4];

  four_channel_note_envelope dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .channel(channel),
    .pitch_height(pitch_height), .note_length(note_length),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .out_channel(out_channel), .volume_level(volume_level),
    .volume_written(volume_written), .timer_reload(timer_reload),
    .octave_select(octave_select), .last_result(last_result)
  );

  note_envelope_checker watch (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .channel(channel),
    .pitch_height(pitch_height), .note_length(note_length),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .out_channel(out_channel), .volume_level(volume_level),
    .volume_written(volume_written), .timer_reload(timer_reload),
    .octave_select(octave_select), .last_result(last_result),
    .mismatches(mismatches), .results_due(results_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("four_channel_note_envelope_tb: FAIL");
      $finish;
    end
  end

  // Gap lengths for both sides: none while calm is set, else mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The result side stalls and runs in bursts, so that stalls land on every result
  // of a tick, including the first and the last of the four.
  initial begin : sink_pacing
    int stall, burst;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      burst = calm ? 16 : $urandom_range(1, 12);
      repeat (burst) @(posedge clk);
    end
  end

  // Offers one item and returns at the edge that accepts it. The valid line stays high
  // when the next item follows straight away; it only drops for a gap.
  task automatic send_item(input logic [1:0] cmd, input logic [1:0] ch,
                           input int height, input logic [15:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    channel <= ch;
    pitch_height <= 8'(height);
    note_length <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender back until every expected result has been taken, then lets the
  // unit finish anything that gives no result. The do-while makes sure the count seen
  // already includes the item accepted at the current edge.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all four envelope words from plan, back to back, with the unit idle.
  task automatic load_words();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_ENV_CH0 + 2'(i);
      cfg_data <= plan[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Attack and decay steps lean towards zero, one and the maximum.
  function automatic logic [6:0] pick_step();
    case ($urandom_range(0, 3))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd127;
      default: return 7'($urandom());
    endcase
  endfunction

  function automatic env_word_t random_word();
    logic [6:0] vol, atk, hld, dec;
    logic [2:0] oct;
    int         roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '1;
    if (roll == 1) return '0;
    vol = 7'($urandom());
    atk = pick_step();
    // Short holds mostly, so that notes reach their decay within a phase.
    hld = ($urandom_range(0, 2) != 0) ? 7'($urandom_range(0, 12)) : 7'($urandom());
    dec = pick_step();
    oct = 3'($urandom());
    return {oct, dec, hld, atk, vol};
  endfunction

  // Ticks dominate, so that started notes are carried through attack, hold and decay.
  task automatic random_item();
    int          roll, height;
    logic [1:0]  cmd;
    logic [15:0] len;
    roll = $urandom_range(0, 99);
    if (roll < 50) cmd = CMD_TICK;
    else if (roll < 80) cmd = CMD_NOTE;
    else if (roll < 95) cmd = CMD_REST;
    else cmd = CMD_SPARE;
    roll = $urandom_range(0, 9);
    if (roll == 0) height = -12;
    else if (roll == 1) height = 95;
    else height = int'($urandom_range(0, 107)) - 12;
    // Durations are mostly short, to race the hold counter; some span the whole field.
    roll = $urandom_range(0, 9);
    if (roll < 6) len = 16'($urandom_range(0, 40));
    else if (roll == 6) len = 16'd0;
    else if (roll == 7) len = 16'hFFFF;
    else len = 16'($urandom());
    send_item(cmd, 2'($urandom()), height, len);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the words left at their reset value (volume 64, attack 127,
    // hold 127, decay 2, base octave 2). The first tick sees every channel idle in
    // decay at level zero, so nothing is written.
    send_item(CMD_TICK, 2'd0, 0, 16'd0);
    // Height zero lowers the octave once; the largest height clamps to the top entry;
    // the lowest height leaves the octave alone; eleven semitones land one below zero.
    send_item(CMD_NOTE, 2'd0, 0, 16'd0);
    send_item(CMD_NOTE, 2'd1, 95, 16'hFFFF);
    send_item(CMD_NOTE, 2'd2, -12, 16'd3);
    send_item(CMD_NOTE, 2'd3, 11, 16'd1);
    // Attack saturates at the wanted volume in one step; hold is cut to the duration.
    send_item(CMD_TICK, 2'd0, 0, 16'd0);
    send_item(CMD_TICK, 2'd0, 0, 16'd0);
    send_item(CMD_REST, 2'd1, 0, 16'd2);
    send_item(CMD_SPARE, 2'd2, 95, 16'hFFFF);
    send_item(CMD_TICK, 2'd0, 0, 16'd0);
    send_item(CMD_TICK, 2'd0, 0, 16'd0);
    drain();

    // Extreme words: all ones on channel zero, all zeros on channel one, a slow attack
    // with zero hold and a zero decay step on channel two, and a two-step attack with
    // a decay step larger than any level on channel three.
    plan[0] = '1;
    plan[1] = '0;
    plan[2] = {3'd7, 7'd0, 7'd0, 7'd1, 7'd127};
    plan[3] = {3'd3, 7'd127, 7'd2, 7'd60, 7'd100};
    load_words();
    // Base octave seven with the largest height walks the octave all the way down.
    send_item(CMD_NOTE, 2'd0, 95, 16'hFFFF);
    send_item(CMD_NOTE, 2'd1, 95, 16'd0);
    send_item(CMD_NOTE, 2'd2, 0, 16'd5);
    send_item(CMD_NOTE, 2'd3, -1, 16'd2);
    repeat (4) send_item(CMD_TICK, 2'd0, 0, 16'd0);
    // A rest drops to decay: a zero step still removes one per tick, a step at least as large
    // as the level clears it at once. The stored level is kept; only the reported one is zero.
    send_item(CMD_REST, 2'd2, 0, 16'd0);
    send_item(CMD_REST, 2'd0, 0, 16'hFFFF);
    repeat (4) send_item(CMD_TICK, 2'd0, 0, 16'd0);
    drain();

    // Random part: a fresh set of words per phase, the sender pausing for the results
    // in between. One phase runs with no gaps on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      for (int i = 0; i < 4; i++) plan[i] = random_word();
      load_words();
      calm = (p == 2);
      repeat (ITEMS_PER_PHASE) random_item();
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0 && results_due == 0) begin
      $display("four_channel_note_envelope_tb: PASS");
    end else begin
      $display("four_channel_note_envelope_tb: FAIL");
    end
    $finish;
  end

endmodule
